// ===== rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants of the cache slot evictor
// Widths, command and policy codes, and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package cse_pkg;
  localparam int CAPACITY = 32;
  localparam int TAG_BITS = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = 6;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_EVICT = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_FIFO = 2'd2;
  localparam logic [1:0] POL_RAND = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_BATCH  = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic             load;       // latch the input request
    logic             scan_start; // begin a victim search
    logic             scan_step;  // compare one slot
    logic             lfsr_step;  // advance the random generator
    logic             rd_vic;     // read the chosen victim slot
    logic             rd_last;    // read the last slot
    logic             rd_idx;     // read the slot at the check index
    logic             move;       // copy the last slot into the victim hole
    logic             remove;     // drop one slot
    logic             append;     // write the new slot
    logic             chk_next;   // advance the expiry check index
  } cse_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] scan_j;
    logic             rand_done;
    logic             mod_busy;
    logic             expired;
  } cse_stat_t;
endpackage

// ===== rtl/cse_datapath.sv =====
// ----------------------------------------------------------------------------
// cse_datapath: slot storage, victim search and removal
// Holds the slot memory, the occupancy, the random victim generator and an
// iterative modulo unit; acts on one command bundle per cycle.
// ----------------------------------------------------------------------------
module cse_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cse_pkg::cse_cmd_t      cmd,
  output cse_pkg::cse_stat_t     stat,
  input  logic [1:0]             policy,
  input  logic                   seed_wr,
  input  logic [15:0]            seed_val,
  input  logic [31:0]            in_now,
  input  logic [15:0]            in_tag,
  input  logic [31:0]            in_ttl,
  output logic [15:0]            victim_tag
);
  import cse_pkg::*;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         ins;
    logic [31:0]         lu;
    logic [15:0]         uc;
    logic [31:0]         ttl;
  } slot_t;

  slot_t mem [CAPACITY];
  slot_t rd_r;
  slot_t last_r;

  logic [CNT_W-1:0] used_r;
  logic [31:0]      now_r, ttl_r, evtot_r;
  logic [15:0]      tag_r, lfsr_r;
  logic [CNT_W-1:0] scan_j_r;
  logic [IDX_W-1:0] vic_r, chk_r;
  logic [31:0]      best_key_r;
  logic             scan_rd_r;
  logic [15:0]      mod_rem_r;
  logic [4:0]       mod_bit_r;
  logic             mod_busy_r, rand_done_r;

  logic [31:0] key;
  always_comb begin
    case (policy)
      POL_LRU: key = rd_r.lu;
      POL_LFU: key = {16'd0, rd_r.uc};
      default: key = rd_r.ins;
    endcase
  end

  // The slot in rd_r becomes the new best when it is the first or strictly lower.
  logic take;
  assign take = scan_rd_r && (scan_j_r == CNT_W'(1) || key < best_key_r);

  logic [15:0] lfsr_nxt;
  assign lfsr_nxt = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);

  // Restoring remainder, one bit per cycle from the top.
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rem_sh  = {mod_rem_r, lfsr_r[mod_bit_r[3:0]]};
  assign rem_sub = rem_sh - {11'd0, used_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      evtot_r     <= '0;
      lfsr_r      <= 16'd1;
      mod_busy_r  <= 1'b0;
      rand_done_r <= 1'b0;
      scan_rd_r   <= 1'b0;
    end else begin
      if (seed_wr) lfsr_r <= (seed_val == 16'd0) ? 16'd1 : seed_val;
      if (cmd.load) begin
        now_r <= in_now;
        tag_r <= in_tag;
        ttl_r <= in_ttl;
        chk_r <= '0;
      end
      if (cmd.chk_next) chk_r <= chk_r + 1'b1;
      if (cmd.scan_start) begin
        scan_j_r   <= '0;
        scan_rd_r  <= 1'b0;
      end
      // A slot read issued in scan_step lands in rd_r in the next cycle.
      if (cmd.scan_step) begin
        rd_r      <= mem[scan_j_r[IDX_W-1:0]];
        scan_rd_r <= 1'b1;
        if (take) best_key_r <= key;
        scan_j_r <= scan_j_r + 1'b1;
      end
      if (cmd.lfsr_step) begin
        lfsr_r      <= lfsr_nxt;
        mod_busy_r  <= 1'b1;
        mod_bit_r   <= 5'd15;
        mod_rem_r   <= '0;
        rand_done_r <= 1'b0;
      end else if (mod_busy_r) begin
        mod_rem_r   <= rem_sub[16] ? rem_sh[15:0] : rem_sub[15:0];
        mod_bit_r   <= mod_bit_r - 1'b1;
        rand_done_r <= (mod_bit_r == 5'd0);
        if (mod_bit_r == 5'd0) mod_busy_r <= 1'b0;
      end else begin
        rand_done_r <= 1'b0;
      end
      if (rand_done_r) vic_r <= mod_rem_r[IDX_W-1:0];
      else if (cmd.scan_start && policy != POL_RAND) vic_r <= '0;
      else if (cmd.scan_step && take)
        vic_r <= IDX_W'(scan_j_r - 1'b1);
      if (cmd.rd_vic) rd_r <= mem[vic_r];
      if (cmd.rd_last) last_r <= mem[IDX_W'(used_r - 1'b1)];
      if (cmd.rd_idx) begin
        rd_r  <= mem[chk_r];
        vic_r <= chk_r;
      end
      if (cmd.remove) begin
        used_r   <= used_r - 1'b1;
        evtot_r  <= evtot_r + 1'b1;
      end
      if (cmd.append) used_r <= used_r + 1'b1;
    end
  end

  // Memory write port: append or hole fill.
  always_ff @(posedge clk) begin
    if (cmd.append)
      mem[used_r[IDX_W-1:0]] <= '{tag: TAG_BITS'(tag_r), ins: now_r, lu: now_r,
                                  uc: 16'd1, ttl: ttl_r};
    else if (cmd.move)
      mem[vic_r] <= last_r;
  end

  assign stat.used      = used_r;
  assign stat.scan_j    = scan_j_r;
  assign stat.rand_done = rand_done_r;
  assign stat.mod_busy  = mod_busy_r;
  assign stat.expired   = (now_r - rd_r.ins) > rd_r.ttl;
  assign victim_tag     = 16'(rd_r.tag);
endmodule

// ===== rtl/cse_ctrl.sv =====
// ----------------------------------------------------------------------------
// cse_ctrl: command sequencer of the cache slot evictor
// Steps through adds, victim searches, removals and the expiry sweep, and hands
// results to the output register.
// ----------------------------------------------------------------------------
module cse_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic [cse_pkg::CNT_W-1:0] in_evict_count,
  input  logic [1:0]                policy,
  input  logic [cse_pkg::CNT_W-1:0] batch,
  input  logic [cse_pkg::CNT_W-1:0] limit,
  input  cse_pkg::cse_stat_t        stat,
  output cse_pkg::cse_cmd_t         cmd,
  input  logic [15:0]               victim_tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_kind,
  output logic [15:0]               out_victim_tag,
  output logic                      out_status,
  output logic [cse_pkg::CNT_W-1:0] out_occupancy,
  output logic                      out_last
);
  import cse_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_RAND  = 4'd4;
  localparam logic [3:0] S_RDV   = 4'd5;
  localparam logic [3:0] S_RDV2  = 4'd6;
  localparam logic [3:0] S_REM   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_ADD   = 4'd9;
  localparam logic [3:0] S_CHK   = 4'd10;
  localparam logic [3:0] S_CHK2  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       op_r;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             status_r, status_nxt;
  logic             ov_r;
  logic             okind_r, ostat_r, olast_r;
  logic [15:0]      otag_r;
  logic [CNT_W-1:0] oocc_r;
  logic [CNT_W-1:0] eff_lim;
  logic [CNT_W-1:0] chk_r;

  always_comb begin
    eff_lim = limit;
    if (limit == '0) eff_lim = CNT_W'(1);
    if (limit > CNT_W'(CAPACITY)) eff_lim = CNT_W'(CAPACITY);
  end

  assign in_ready = (state_r == S_IDLE);
  logic out_free;
  assign out_free = !ov_r || out_ready;

  logic full;
  assign full = stat.used >= eff_lim;

  always_comb begin
    state_nxt  = state_r;
    left_nxt   = left_r;
    status_nxt = status_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load   = 1'b1;
        status_nxt = 1'b0;
        left_nxt   = in_evict_count;
        state_nxt  = S_DISP;
      end
      S_DISP: begin
        case (op_r)
          CMD_ADD: begin
            left_nxt  = full ? batch : '0;
            state_nxt = S_PICK;
          end
          CMD_EVICT: state_nxt = S_PICK;
          CMD_CLEAR: state_nxt = S_CHK;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_PICK: begin
        if (left_r != '0 && stat.used != '0) begin
          cmd.scan_start = 1'b1;
          cmd.lfsr_step  = (policy == POL_RAND);
          state_nxt      = (policy == POL_RAND) ? S_RAND : S_SCAN;
        end else if (op_r == CMD_ADD) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        // The last used slot is compared in the cycle that the index reaches used.
        if (stat.scan_j >= stat.used) state_nxt = S_RDV;
      end
      S_RAND: if (stat.rand_done) state_nxt = S_RDV;
      // The victim slot is read from memory here, after the search settles.
      S_RDV: begin
        cmd.rd_vic = 1'b1;
        state_nxt  = S_RDV2;
      end
      S_RDV2: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_REM;
      end
      S_REM: begin
        cmd.move = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: if (out_free) begin
        cmd.remove = 1'b1;
        if (op_r == CMD_CLEAR) begin
          state_nxt = S_CHK;
        end else begin
          left_nxt  = left_r - 1'b1;
          state_nxt = S_PICK;
        end
      end
      S_ADD: begin
        if (full) status_nxt = 1'b1;
        else cmd.append = 1'b1;
        state_nxt = S_DONE;
      end
      S_CHK: begin
        if (chk_r >= stat.used) state_nxt = S_DONE;
        else begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_CHK2;
        end
      end
      S_CHK2: begin
        if (stat.expired) begin
          cmd.rd_last = 1'b1;
          state_nxt   = S_REM;
        end else begin
          cmd.chk_next = 1'b1;
          state_nxt    = S_CHK;
        end
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      left_r   <= '0;
      status_r <= 1'b0;
      chk_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      left_r   <= left_nxt;
      status_r <= status_nxt;
      if (cmd.load) begin
        op_r  <= in_cmd;
        chk_r <= '0;
      end
      if (cmd.chk_next) chk_r <= chk_r + 1'b1;
      if (state_r == S_EMIT && out_free) begin
        ov_r    <= 1'b1;
        okind_r <= 1'b0;
        ostat_r <= 1'b0;
        olast_r <= 1'b0;
        otag_r  <= victim_tag;
        oocc_r  <= stat.used - 1'b1;
      end else if (state_r == S_DONE && out_free) begin
        ov_r    <= 1'b1;
        okind_r <= 1'b1;
        ostat_r <= status_r;
        olast_r <= 1'b1;
        otag_r  <= '0;
        oocc_r  <= stat.used;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_kind       = okind_r;
  assign out_victim_tag = otag_r;
  assign out_status     = ostat_r;
  assign out_occupancy  = oocc_r;
  assign out_last       = olast_r;
endmodule

// ===== rtl/cache_slot_evictor.sv =====
// ----------------------------------------------------------------------------
// cache_slot_evictor: cache slot table with selectable eviction
// Top level joining the command sequencer, the slot datapath and the
// configuration registers.
// ----------------------------------------------------------------------------
// One request is worked at a time. An add without eviction steps through the
// dispatch, pick, add and done states; each victim costs a search of the used
// slots (one slot per cycle, or a bit-serial modulo for the random policy) plus
// the read-victim, read-last, move and emit removal steps, and clear-expired
// reads and checks one slot at a time. A finished result sits in an output
// register, so the table keeps working while it waits.
module cache_slot_evictor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_entry_tag,
  input  logic [31:0] in_entry_ttl,
  input  logic [5:0]  in_evict_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [15:0] out_victim_tag,
  output logic        out_status,
  output logic [5:0]  out_occupancy,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cse_pkg::*;

  logic [1:0]       policy_r;
  logic [CNT_W-1:0] batch_r, limit_r;
  cse_cmd_t         cmd;
  cse_stat_t        stat;
  logic [15:0]      vtag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_LRU;
      batch_r  <= CNT_W'(1);
      limit_r  <= CNT_W'(CAPACITY);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLICY: policy_r <= cfg_data[1:0];
        REG_BATCH:  batch_r  <= cfg_data[CNT_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  cse_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_evict_count,
    .policy(policy_r), .batch(batch_r), .limit(limit_r), .stat, .cmd,
    .victim_tag(vtag), .out_valid, .out_ready, .out_kind, .out_victim_tag,
    .out_status, .out_occupancy, .out_last
  );

  cse_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .policy(policy_r),
    .seed_wr(cfg_we && cfg_index == REG_SEED), .seed_val(cfg_data),
    .in_now(in_now_ms), .in_tag(in_entry_tag), .in_ttl(in_entry_ttl),
    .victim_tag(vtag)
  );
endmodule

// ===== rtl/cse_checker.sv =====
// ----------------------------------------------------------------------------
// cse_checker: port-level checks of the cache slot evictor
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module cse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [15:0] out_victim_tag,
  input logic        out_status,
  input logic [5:0]  out_occupancy,
  input logic        out_last
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_tag))
    else $error("result changed while stalled");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == out_kind)
    else $error("last flag differs from done kind");
  a_done_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_victim_tag == 16'd0)
    else $error("done result carries a tag");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= 6'd32)
    else $error("occupancy beyond capacity");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_status)
    else $error("status set on a report");
endmodule

bind cache_slot_evictor cse_checker u_cse_checker (.*);
